FILE: sv/char_stream_tokenizer_macros.svh
// assertion macros shared by the tokenizer checker
`ifndef CHAR_STREAM_TOKENIZER_MACROS_SVH
`define CHAR_STREAM_TOKENIZER_MACROS_SVH

// clocked check, switched off while reset is held
`define CST_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also covers the reset cycles
`define CST_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/cst_pkg.sv
// shared types and constants of the character stream tokenizer
package cst_pkg;

    localparam int MAX_WORD_LENGTH = 127;
    localparam int WORD_LIMIT_INT  = (MAX_WORD_LENGTH < 127) ? MAX_WORD_LENGTH : 127;
    localparam logic [6:0] WORD_LIMIT = 7'(WORD_LIMIT_INT);

    // result queue, power of two
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef enum logic [3:0] {
        KIND_END     = 4'd0,
        KIND_INT     = 4'd1,
        KIND_IF      = 4'd2,
        KIND_IDENT   = 4'd3,
        KIND_NUMBER  = 4'd4,
        KIND_ASSIGN  = 4'd5,
        KIND_PLUS    = 4'd6,
        KIND_MINUS   = 4'd7,
        KIND_STAR    = 4'd8,
        KIND_SLASH   = 4'd9,
        KIND_LPAREN  = 4'd10,
        KIND_RPAREN  = 4'd11,
        KIND_LBRACE  = 4'd12,
        KIND_RBRACE  = 4'd13,
        KIND_SEMI    = 4'd14,
        KIND_UNKNOWN = 4'd15
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_WORD   = 2'd1,
        MODE_NUMBER = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        KW_NONE = 3'd0,
        KW_I    = 3'd1,
        KW_IN   = 3'd2,
        KW_INT  = 3'd3,
        KW_IF   = 3'd4
    } kw_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] number_value;
        logic [6:0] word_length;
        logic [7:0] token_char;
        logic       last_of_item;
    } token_t;

    typedef struct packed {
        mode_t      mode;
        logic [6:0] word_count;
        logic [7:0] number_acc;
        kw_t        kw;
    } lex_state_t;

    typedef struct packed {
        logic [1:0] n_tokens;
        token_t     tok0;
        token_t     tok1;
        lex_state_t state_next;
    } lex_result_t;

    localparam token_t TOKEN_ZERO = '{kind: KIND_END, number_value: 8'd0,
                                      word_length: 7'd0, token_char: 8'd0,
                                      last_of_item: 1'b0};

    localparam lex_state_t LEX_STATE_RESET = '{mode: MODE_IDLE, word_count: 7'd0,
                                               number_acc: 8'd0, kw: KW_NONE};

endpackage

FILE: sv/cst_lexer_core.sv
// one-character scan step: classifies the byte, updates the scan state, builds tokens
module cst_lexer_core
    import cst_pkg::*;
(
    input  logic [7:0]  char_code,
    input  logic        end_of_text,
    input  lex_state_t  state_cur,
    output lex_result_t result
);

    localparam logic [7:0] CH_LOWER_I = "i";
    localparam logic [7:0] CH_LOWER_N = "n";
    localparam logic [7:0] CH_LOWER_T = "t";
    localparam logic [7:0] CH_LOWER_F = "f";
    localparam logic [7:0] CH_ZERO    = "0";

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
    endfunction

    function automatic kind_t op_kind(input logic [7:0] c);
        kind_t k;
        unique case (c)
            "=":     k = KIND_ASSIGN;
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            ";":     k = KIND_SEMI;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    logic       c_letter;
    logic       c_digit;
    logic       c_space;
    logic       in_word;
    logic       in_number;
    logic       has_pend;
    logic [7:0] digit_val;
    logic [7:0] acc_times_ten;
    token_t     pend_tok;
    token_t     op_tok;
    token_t     end_tok;
    kw_t        kw_ext;
    lex_result_t res;

    assign c_letter  = is_letter(char_code);
    assign c_digit   = is_digit(char_code);
    assign c_space   = is_space(char_code);
    assign in_word   = (state_cur.mode == MODE_WORD);
    assign in_number = (state_cur.mode == MODE_NUMBER);
    assign has_pend  = in_word || in_number;
    assign digit_val = char_code - CH_ZERO;
    // times ten as two shifts, kept modulo 256
    assign acc_times_ten = {state_cur.number_acc[4:0], 3'b000}
                         + {state_cur.number_acc[6:0], 1'b0};

    always_comb begin
        priority if (state_cur.kw == KW_I && char_code == CH_LOWER_N) begin
            kw_ext = KW_IN;
        end else if (state_cur.kw == KW_I && char_code == CH_LOWER_F) begin
            kw_ext = KW_IF;
        end else if (state_cur.kw == KW_IN && char_code == CH_LOWER_T) begin
            kw_ext = KW_INT;
        end else begin
            kw_ext = KW_NONE;
        end
    end

    always_comb begin
        pend_tok = TOKEN_ZERO;
        if (in_word) begin
            unique case (state_cur.kw)
                KW_INT:  pend_tok.kind = KIND_INT;
                KW_IF:   pend_tok.kind = KIND_IF;
                default: pend_tok.kind = KIND_IDENT;
            endcase
            pend_tok.word_length = state_cur.word_count;
        end else begin
            pend_tok.kind         = KIND_NUMBER;
            pend_tok.number_value = state_cur.number_acc;
        end
        op_tok            = TOKEN_ZERO;
        op_tok.kind       = op_kind(char_code);
        op_tok.token_char = char_code;
        end_tok           = TOKEN_ZERO;
    end

    always_comb begin
        res            = '0;
        res.tok0       = TOKEN_ZERO;
        res.tok1       = TOKEN_ZERO;
        res.state_next = state_cur;
        if (end_of_text) begin
            res.state_next = LEX_STATE_RESET;
            if (has_pend) begin
                res.n_tokens = 2'd2;
                res.tok0     = pend_tok;
                res.tok1     = end_tok;
            end else begin
                res.n_tokens = 2'd1;
                res.tok0     = end_tok;
            end
        end else if (in_word && (c_letter || c_digit)) begin
            if (state_cur.word_count < WORD_LIMIT) begin
                res.state_next.word_count = state_cur.word_count + 7'd1;
            end
            res.state_next.kw = kw_ext;
        end else if (in_number && c_digit) begin
            res.state_next.number_acc = acc_times_ten + digit_val;
        end else begin
            // pending token closes; the byte then starts something new
            res.state_next = LEX_STATE_RESET;
            if (c_letter) begin
                res.state_next.mode       = MODE_WORD;
                res.state_next.word_count = 7'd1;
                res.state_next.kw         = (char_code == CH_LOWER_I) ? KW_I : KW_NONE;
            end else if (c_digit) begin
                res.state_next.mode       = MODE_NUMBER;
                res.state_next.number_acc = digit_val;
            end
            if (has_pend) begin
                res.tok0 = pend_tok;
                if (!c_space && !c_letter && !c_digit) begin
                    res.n_tokens = 2'd2;
                    res.tok1     = op_tok;
                end else begin
                    res.n_tokens = 2'd1;
                end
            end else if (!c_space && !c_letter && !c_digit) begin
                res.n_tokens = 2'd1;
                res.tok0     = op_tok;
            end
        end
        if (res.n_tokens == 2'd1) begin
            res.tok0.last_of_item = 1'b1;
        end
        if (res.n_tokens == 2'd2) begin
            res.tok1.last_of_item = 1'b1;
        end
    end

    assign result = res;

endmodule

FILE: sv/cst_token_fifo.sv
// small token queue taking up to two tokens and giving one per cycle while popped
module cst_token_fifo
    import cst_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         push_cnt,
    input  token_t             push0,
    input  token_t             push1,
    input  logic               pop,
    output token_t             head,
    output logic [FIFO_CW-1:0] count
);

    token_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;

    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign count_next  = count_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_reg + FIFO_AW'(1)] <= push1;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

FILE: sv/char_stream_tokenizer.sv
// top level of the byte-serial tokenizer: input register, scan step, token queue
//
// Takes one source byte per request and returns tokens: keywords int and if,
// identifiers with a saturating length, decimal numbers modulo 256, the ten
// single-character operators and unknown bytes, plus an end token for each
// end-of-text request. A request is taken every cycle while the four-entry
// token queue has room for two more tokens; it is held in the input
// register, where the scan step decides its tokens and the next scan state,
// and its tokens go into the queue, whose head drives m_valid, as the
// register moves on. The queue drains one token per cycle while m_ready
// is high, so the sustained rate is one request per cycle as long as
// requests average at most one token each; a request that closes a word
// or number and also yields its own token leaves two tokens to drain.
module char_stream_tokenizer
    import cst_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // source byte requests
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_end_of_text,
    // token results
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_token_kind,
    output logic [7:0] m_number_value,
    output logic [6:0] m_word_length,
    output logic [7:0] m_token_char,
    output logic       m_last_of_item
);

    localparam logic [FIFO_CW-1:0] ROOM_LIMIT = FIFO_CW'(FIFO_DEPTH - 2);

    // input register
    logic        stage_valid_reg;
    logic [7:0]  stage_char_reg;
    logic        stage_eot_reg;
    // scan state that carries from byte to byte
    lex_state_t  state_reg;

    lex_result_t lex_res;
    token_t      head;
    logic [FIFO_CW-1:0] fifo_count;
    logic        proceed;
    logic        pop;
    logic [1:0]  push_cnt;

    // the staged byte moves on once the queue can hold both of its tokens
    assign proceed  = stage_valid_reg && (fifo_count <= ROOM_LIMIT);
    assign s_ready  = !stage_valid_reg || proceed;
    assign pop      = m_valid && m_ready;
    assign push_cnt = proceed ? lex_res.n_tokens : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            state_reg       <= LEX_STATE_RESET;
        end else begin
            if (s_ready) begin
                stage_valid_reg <= s_valid;
            end
            if (proceed) begin
                state_reg <= lex_res.state_next;
            end
        end
    end

    // payload of the input register, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stage_char_reg <= s_char_code;
            stage_eot_reg  <= s_end_of_text;
        end
    end

    cst_lexer_core u_core (
        .char_code   (stage_char_reg),
        .end_of_text (stage_eot_reg),
        .state_cur   (state_reg),
        .result      (lex_res)
    );

    cst_token_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .push0    (lex_res.tok0),
        .push1    (lex_res.tok1),
        .pop      (pop),
        .head     (head),
        .count    (fifo_count)
    );

    // head of the queue drives the result ports
    assign m_valid        = (fifo_count != '0);
    assign m_token_kind   = head.kind;
    assign m_number_value = head.number_value;
    assign m_word_length  = head.word_length;
    assign m_token_char   = head.token_char;
    assign m_last_of_item = head.last_of_item;

endmodule

FILE: sv/cst_checker.sv
// port-level checks of the tokenizer and their binding to the top level
`include "char_stream_tokenizer_macros.svh"

module cst_checker
    import cst_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_token_kind,
    input logic [7:0] m_number_value,
    input logic [6:0] m_word_length,
    input logic [7:0] m_token_char,
    input logic       m_last_of_item
);

    `CST_ASSERT_ALWAYS(a_idle_after_reset, aclk, !aresetn |=> !m_valid,
        "token shown right after reset")
    `CST_ASSERT(a_result_holds, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind)
            && $stable(m_number_value) && $stable(m_word_length)
            && $stable(m_token_char) && $stable(m_last_of_item),
        "stalled token changed")
    `CST_ASSERT(a_end_is_last, aclk, aresetn,
        m_valid && m_token_kind == KIND_END |->
            m_last_of_item && m_number_value == 8'd0 && m_word_length == 7'd0,
        "end token malformed")
    `CST_ASSERT(a_keyword_length, aclk, aresetn,
        m_valid && m_token_kind == KIND_INT |-> m_word_length == 7'd3,
        "int keyword with wrong length")
    `CST_ASSERT(a_number_fields, aclk, aresetn,
        m_valid && m_token_kind == KIND_NUMBER |->
            m_word_length == 7'd0 && m_token_char == 8'd0,
        "number token carries word fields")

endmodule

bind char_stream_tokenizer cst_checker u_cst_checker (.*);

FILE: sim/tb.sv
// testbench of the character stream tokenizer: directed table, random source text, token scoreboard
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cst_pkg::*;

    // request budget of the random part, spread over four idling phases
    localparam int RANDOM_REQUESTS = 1250;
    localparam int PHASES          = 4;
    // the first mismatches are printed, the rest only counted
    localparam int MAX_REPORTS     = 10;
    // slack given to owed tokens before the final check
    localparam int DRAIN_CYCLES    = 20;
    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    // one row of the directed table; a typed row carries its own expectation
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       typed;
        logic [1:0] n_typed;
        kind_t      kind;
    } stim_row_t;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_code    = 8'd0;
    logic       s_end_of_text  = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [3:0] m_token_kind;
    logic [7:0] m_number_value;
    logic [6:0] m_word_length;
    logic [7:0] m_token_char;
    logic       m_last_of_item;

    char_stream_tokenizer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_end_of_text  (s_end_of_text),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_number_value (m_number_value),
        .m_word_length  (m_word_length),
        .m_token_char   (m_token_char),
        .m_last_of_item (m_last_of_item)
    );

    always #5 aclk = ~aclk;

    // scanner state mirrored by the predictor
    mode_t      lex_mode  = MODE_IDLE;
    logic [6:0] lex_count = 7'd0;
    logic [7:0] lex_acc   = 8'd0;
    kw_t        lex_kw    = KW_NONE;

    // tokens produced by the latest request, and tokens still owed by the block
    token_t scan_out[$];
    token_t tokens_due[$];
    token_t due;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int requests_sent  = 0;
    int error_count    = 0;

    // ---------------------------------------------------------------
    // character classes
    // ---------------------------------------------------------------
    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
    endfunction

    function automatic kind_t op_kind(input logic [7:0] c);
        case (c)
            "=": return KIND_ASSIGN;
            "+": return KIND_PLUS;
            "-": return KIND_MINUS;
            "*": return KIND_STAR;
            "/": return KIND_SLASH;
            "(": return KIND_LPAREN;
            ")": return KIND_RPAREN;
            "{": return KIND_LBRACE;
            "}": return KIND_RBRACE;
            ";": return KIND_SEMI;
            default: return KIND_UNKNOWN;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    // emit the word or number in progress, if any, and go back to idle
    function void close_pending();
        token_t t;
        t = TOKEN_ZERO;
        if (lex_mode == MODE_WORD) begin
            if (lex_kw == KW_INT)
                t.kind = KIND_INT;
            else if (lex_kw == KW_IF)
                t.kind = KIND_IF;
            else
                t.kind = KIND_IDENT;
            t.word_length = lex_count;
            scan_out.push_back(t);
        end else if (lex_mode == MODE_NUMBER) begin
            t.kind = KIND_NUMBER;
            t.number_value = lex_acc;
            scan_out.push_back(t);
        end
        lex_mode  = MODE_IDLE;
        lex_count = 7'd0;
        lex_acc   = 8'd0;
        lex_kw    = KW_NONE;
    endfunction

    // one request through the scanner; its tokens land in scan_out
    function void scan_byte(input logic [7:0] c, input logic eot);
        token_t t;
        scan_out.delete();
        t = TOKEN_ZERO;
        if (eot) begin
            // pending word or number first, then the end token
            close_pending();
            scan_out.push_back(t);
        end else if (lex_mode == MODE_WORD && (is_letter(c) || is_digit(c))) begin
            // length saturates, keyword match only follows the leading characters
            if (lex_count < WORD_LIMIT)
                lex_count = lex_count + 7'd1;
            if (lex_kw == KW_I && c == "n")
                lex_kw = KW_IN;
            else if (lex_kw == KW_I && c == "f")
                lex_kw = KW_IF;
            else if (lex_kw == KW_IN && c == "t")
                lex_kw = KW_INT;
            else
                lex_kw = KW_NONE;
        end else if (lex_mode == MODE_NUMBER && is_digit(c)) begin
            lex_acc = 8'(lex_acc * 8'd10 + (c - "0"));
        end else begin
            // the byte ends whatever was pending and starts something new
            close_pending();
            if (is_letter(c)) begin
                lex_mode  = MODE_WORD;
                lex_count = 7'd1;
                lex_kw    = (c == "i") ? KW_I : KW_NONE;
            end else if (is_digit(c)) begin
                lex_mode = MODE_NUMBER;
                lex_acc  = c - "0";
            end else if (!is_space(c)) begin
                t.kind       = op_kind(c);
                t.token_char = c;
                scan_out.push_back(t);
            end
        end
        if (scan_out.size() > 0) begin
            t = scan_out.pop_back();
            t.last_of_item = 1'b1;
            scan_out.push_back(t);
        end
    endfunction

    function automatic stim_row_t row(input logic [7:0] ch, input logic eot,
                                      input logic typed, input logic [1:0] n_typed,
                                      input kind_t kind);
        stim_row_t r;
        r.ch      = ch;
        r.eot     = eot;
        r.typed   = typed;
        r.n_typed = n_typed;
        r.kind    = kind;
        return r;
    endfunction

    function void note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // ---------------------------------------------------------------
    // request driver: enters and leaves on a falling edge
    // ---------------------------------------------------------------
    task automatic send_request(input logic [7:0] ch, input logic eot, input logic typed,
                                input logic [1:0] n_typed, input kind_t kind);
        token_t t;
        // random sender gaps before the request
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_char_code   = ch;
        s_end_of_text = eot;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // request taken at this edge: update the predictor
        scan_byte(ch, eot);
        if (typed) begin
            if (n_typed != 2'd0) begin
                t              = TOKEN_ZERO;
                t.kind         = kind;
                t.token_char   = (kind == KIND_END) ? 8'd0 : ch;
                t.last_of_item = 1'b1;
                tokens_due.push_back(t);
            end
        end else begin
            foreach (scan_out[i])
                tokens_due.push_back(scan_out[i]);
        end
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_request(ch, 1'b0, PREDICTED, 2'd0, KIND_END);
    endtask

    // a word of n characters with random letters, digits and underscores
    task automatic send_word(input int n);
        string head_set;
        string tail_set;
        head_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        tail_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        send_char(head_set[$urandom_range(0, head_set.len() - 1)]);
        for (int i = 1; i < n; i++)
            send_char(tail_set[$urandom_range(0, tail_set.len() - 1)]);
    endtask

    // one piece of source text: mostly well-formed tokens, some noise
    task automatic random_token();
        string w;
        string op_set;
        int    pick;
        int    n;
        op_set = "=+-*/(){};";
        pick   = $urandom_range(0, 99);
        if (pick < 30) begin
            if ($urandom_range(0, 1)) begin
                // keywords and near misses of them
                case ($urandom_range(0, 7))
                    0: w = "int";
                    1: w = "if";
                    2: w = "i";
                    3: w = "in";
                    4: w = "intx";
                    5: w = "if_9";
                    6: w = "Int";
                    default: w = "iff";
                endcase
                for (int i = 0; i < w.len(); i++)
                    send_char(w[i]);
            end else begin
                send_word($urandom_range(1, 8));
            end
        end else if (pick < 50) begin
            // numbers, sometimes long enough to wrap several times
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                send_char(8'h30 + 8'($urandom_range(0, 9)));
        end else if (pick < 68) begin
            send_char(op_set[$urandom_range(0, op_set.len() - 1)]);
        end else if (pick < 82) begin
            send_char(($urandom_range(0, 5) == 5) ? 8'd32 : 8'(9 + $urandom_range(0, 4)));
        end else if (pick < 90) begin
            send_char(8'($urandom));
        end else if (pick < 95) begin
            send_char(8'($urandom_range(128, 255)));
        end else begin
            // end of text; the byte beside it is ignored
            send_request(8'($urandom), 1'b1, PREDICTED, 2'd0, KIND_END);
        end
    endtask

    // hold requests back until every owed token has come out
    task automatic wait_drained();
        s_valid = 1'b0;
        while (tokens_due.size() != 0)
            @(negedge aclk);
    endtask

    // ---------------------------------------------------------------
    // receiver: random stalls, changed on the falling edge
    // ---------------------------------------------------------------
    always @(negedge aclk)
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // ---------------------------------------------------------------
    // token checker: every accepted token against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (tokens_due.size() == 0) begin
                note_failure($sformatf("token with none expected: kind %0d num %0d len %0d char %0d last %0d",
                                       m_token_kind, m_number_value, m_word_length,
                                       m_token_char, m_last_of_item));
            end else begin
                due = tokens_due.pop_front();
                if (m_token_kind !== due.kind || m_number_value !== due.number_value ||
                    m_word_length !== due.word_length || m_token_char !== due.token_char ||
                    m_last_of_item !== due.last_of_item) begin
                    note_failure($sformatf({"token mismatch: expected kind %0d num %0d len %0d ",
                                            "char %0d last %0d, got kind %0d num %0d len %0d ",
                                            "char %0d last %0d"},
                                           due.kind, due.number_value, due.word_length,
                                           due.token_char, due.last_of_item,
                                           m_token_kind, m_number_value, m_word_length,
                                           m_token_char, m_last_of_item));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    initial begin
        stim_row_t rows[$];
        int        phase_end;

        // end of text while idle, every operator, bytes at both ends, whitespace
        rows.push_back(row(8'hA5, 1'b1, TYPED, 2'd1, KIND_END));
        rows.push_back(row("=",   1'b0, TYPED, 2'd1, KIND_ASSIGN));
        rows.push_back(row("+",   1'b0, TYPED, 2'd1, KIND_PLUS));
        rows.push_back(row("-",   1'b0, TYPED, 2'd1, KIND_MINUS));
        rows.push_back(row("*",   1'b0, TYPED, 2'd1, KIND_STAR));
        rows.push_back(row("/",   1'b0, TYPED, 2'd1, KIND_SLASH));
        rows.push_back(row("(",   1'b0, TYPED, 2'd1, KIND_LPAREN));
        rows.push_back(row(")",   1'b0, TYPED, 2'd1, KIND_RPAREN));
        rows.push_back(row("{",   1'b0, TYPED, 2'd1, KIND_LBRACE));
        rows.push_back(row("}",   1'b0, TYPED, 2'd1, KIND_RBRACE));
        rows.push_back(row(";",   1'b0, TYPED, 2'd1, KIND_SEMI));
        rows.push_back(row(8'h00, 1'b0, TYPED, 2'd1, KIND_UNKNOWN));
        rows.push_back(row(8'hFF, 1'b0, TYPED, 2'd1, KIND_UNKNOWN));
        rows.push_back(row(8'd9,  1'b0, TYPED, 2'd0, KIND_END));
        // keyword int closed by an operator: two tokens from one request
        rows.push_back(row("i",   1'b0, PREDICTED, 2'd0, KIND_END));
        rows.push_back(row("n",   1'b0, PREDICTED, 2'd0, KIND_END));
        rows.push_back(row("t",   1'b0, PREDICTED, 2'd0, KIND_END));
        rows.push_back(row(";",   1'b0, PREDICTED, 2'd0, KIND_END));
        // keyword if flushed by end of text
        rows.push_back(row("i",   1'b0, PREDICTED, 2'd0, KIND_END));
        rows.push_back(row("f",   1'b0, PREDICTED, 2'd0, KIND_END));
        rows.push_back(row(8'h5A, 1'b1, PREDICTED, 2'd0, KIND_END));
        // number that wraps past 255, closed by an operator
        rows.push_back(row("2",   1'b0, PREDICTED, 2'd0, KIND_END));
        rows.push_back(row("9",   1'b0, PREDICTED, 2'd0, KIND_END));
        rows.push_back(row("9",   1'b0, PREDICTED, 2'd0, KIND_END));
        rows.push_back(row("+",   1'b0, PREDICTED, 2'd0, KIND_END));

        // synchronous reset, released on a falling edge
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i])
            send_request(rows[i].ch, rows[i].eot, rows[i].typed, rows[i].n_typed, rows[i].kind);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 85;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 85;
                end
                default: begin
                    send_idle_pct  = 38;
                    recv_stall_pct = 38;
                end
            endcase
            phase_end = requests_sent + RANDOM_REQUESTS / PHASES;
            // one word of 126 to 140 characters, around the length limit, in every phase
            send_word($urandom_range(126, 140));
            while (requests_sent < phase_end)
                random_token();
            // sender pauses until every owed token is out
            wait_drained();
        end

        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tokens_due.size() != 0)
            note_failure($sformatf("%0d tokens never arrived", tokens_due.size()));
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/cst_pkg.sv
sv/cst_lexer_core.sv
sv/cst_token_fifo.sv
sv/char_stream_tokenizer.sv
sv/cst_checker.sv
sim/tb.sv
